>>> src/fra_pkg.sv
`default_nettype none
package fra_pkg;

    // Default sizing for the allocator
    localparam int unsigned DefNumKinds  = 4;
    localparam int unsigned DefMaxRanges = 16;
    localparam int unsigned DefIndexBits = 16;

endpackage
`default_nettype wire

>>> src/first_fit_range_allocator.sv
`default_nettype none
// Flow (accept to result valid): a claim first scans the held ranges for one that it can extend;
//   a claim that needs a new range appends it, then runs P bubble passes over the n held ranges
//   (1 to n+1). An allocate first runs a first-fit scan over the held ranges, then claims.
// Items are taken one at a time; each entry visited costs a memory read, then a check.
//   The input stalls from accept until the result moves into the output register.
// Reset: rst_n asynchronous active low clears range counts and control; memory is not cleared.
module first_fit_range_allocator #(
    parameter int unsigned NUM_KINDS  = fra_pkg::DefNumKinds,
    parameter int unsigned MAX_RANGES = fra_pkg::DefMaxRanges,
    parameter int unsigned INDEX_BITS = fra_pkg::DefIndexBits
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [1:0]  kind,
    input  wire logic [15:0] range_start,
    input  wire logic [15:0] range_stop,
    input  wire logic [15:0] amount,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      index,
    output logic             table_full,
    output logic             index_overflow
);
    import fra_pkg::*;

    // widths
    localparam int unsigned KB    = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
    localparam int unsigned RB    = $clog2(MAX_RANGES);
    localparam int unsigned CW    = $clog2(MAX_RANGES + 1);
    localparam int unsigned AB    = KB + RB;
    localparam int unsigned DEPTH = NUM_KINDS << RB;
    localparam int unsigned IW    = INDEX_BITS;
    localparam int unsigned WX    = (INDEX_BITS > 16) ? INDEX_BITS : 16;
    localparam int unsigned SW    = WX + 1;
    localparam int unsigned EW    = 2 * IW;

    typedef logic [EW-1:0] entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_C_RD,   // claim scan: read entry
        ST_C_CHK,  // claim scan: test for an abutting neighbor
        ST_C_MISS, // no neighbor: append new range, or flag table full
        ST_S_RD,   // bubble pass: read entry
        ST_S_CHK,  // bubble pass: compare with carried entry
        ST_S_END,  // bubble pass: park carried entry at the top
        ST_A_RD,   // first-fit scan: read entry
        ST_A_CHK,  // first-fit scan: test gap
        ST_A_END,  // first-fit result, go claim it, or flag overflow
        ST_DONE    // result ready, wait for output register
    } state_t;

    // range memory, {begin, finish} per entry, addressed {kind, slot}
    entry_t mem [0:DEPTH-1];
    entry_t rdata_reg;
    logic          rd_en;
    logic [AB-1:0] raddr;
    logic          we;
    logic [AB-1:0] waddr;
    entry_t        wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    state_t          state_reg,   state_next;
    logic [CW-1:0]   held_reg [0:(1<<KB)-1];
    logic            held_we;
    logic [KB-1:0]   kind_reg,    kind_next;
    logic [IW-1:0]   start_reg,   start_next;
    logic [IW-1:0]   stop_reg,    stop_next;
    logic [15:0]     amount_reg,  amount_next;
    logic [IW-1:0]   base_reg,    base_next;
    logic [CW-1:0]   i_reg,       i_next;
    logic [CW-1:0]   n_reg,       n_next;
    entry_t          carry_reg,   carry_next;
    logic            swapped_reg, swapped_next;
    logic [15:0]     res_idx_reg, res_idx_next;
    logic            res_full_reg, res_full_next;
    logic            res_ovf_reg,  res_ovf_next;
    logic            out_valid_reg, out_valid_next;
    logic [15:0]     index_reg,   index_next;
    logic            full_reg,    full_next;
    logic            ovf_reg,     ovf_next;

    // input fields masked to the index range
    logic [WX-1:0] in_start_x, in_stop_x, base_x;
    logic [IW-1:0] in_start_m, in_stop_m;
    logic          kind_ok;
    logic [IW-1:0] rd_begin, rd_finish, cy_begin, cy_finish;
    logic [SW-1:0] fit_end;
    logic          carry_gt;
    logic [CW-1:0] i_inc;

    assign in_start_x = WX'(range_start);
    assign in_stop_x  = WX'(range_stop);
    assign in_start_m = in_start_x[IW-1:0];
    assign in_stop_m  = in_stop_x[IW-1:0];
    assign base_x     = WX'(base_reg);
    assign kind_ok    = 32'(kind) < NUM_KINDS;
    assign rd_begin   = rdata_reg[EW-1:IW];
    assign rd_finish  = rdata_reg[IW-1:0];
    assign cy_begin   = carry_reg[EW-1:IW];
    assign cy_finish  = carry_reg[IW-1:0];
    assign fit_end    = SW'(base_reg) + SW'(amount_reg);
    assign carry_gt   = (cy_begin > rd_begin) ||
                        ((cy_begin == rd_begin) && (cy_finish > rd_finish));
    assign i_inc      = i_reg + CW'(1);

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        start_next     = start_reg;
        stop_next      = stop_reg;
        amount_next    = amount_reg;
        base_next      = base_reg;
        i_next         = i_reg;
        n_next         = n_reg;
        carry_next     = carry_reg;
        swapped_next   = swapped_reg;
        res_idx_next   = res_idx_reg;
        res_full_next  = res_full_reg;
        res_ovf_next   = res_ovf_reg;
        out_valid_next = out_valid_reg && out_stall;
        index_next     = index_reg;
        full_next      = full_reg;
        ovf_next       = ovf_reg;
        rd_en          = 1'b0;
        raddr          = {kind_reg, i_reg[RB-1:0]};
        we             = 1'b0;
        waddr          = {kind_reg, i_reg[RB-1:0]};
        wdata          = rdata_reg;
        held_we        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next     = KB'(kind);
                    start_next    = in_start_m;
                    stop_next     = in_stop_m;
                    amount_next   = amount;
                    base_next     = '0;
                    i_next        = '0;
                    n_next        = held_reg[KB'(kind)];
                    res_full_next = 1'b0;
                    res_ovf_next  = 1'b0;
                    res_idx_next  = op ? 16'd0 : 16'(in_start_m);
                    if (!kind_ok)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (!op)
                    begin
                        state_next = (held_reg[KB'(kind)] == '0) ? ST_C_MISS : ST_C_RD;
                    end
                    else
                    begin
                        state_next = (held_reg[KB'(kind)] == '0) ? ST_A_END : ST_A_RD;
                    end
                end
            end
            ST_C_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_C_CHK;
            end
            ST_C_CHK:
            begin
                // begin side wins over finish side; only one is extended
                if (rd_begin == stop_reg)
                begin
                    we         = 1'b1;
                    wdata      = {start_reg, rd_finish};
                    state_next = ST_DONE;
                end
                else if (rd_finish == start_reg)
                begin
                    we         = 1'b1;
                    wdata      = {rd_begin, stop_reg};
                    state_next = ST_DONE;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = (i_inc == n_reg) ? ST_C_MISS : ST_C_RD;
                end
            end
            ST_C_MISS:
            begin
                if (32'(n_reg) >= MAX_RANGES)
                begin
                    res_full_next = 1'b1;
                    state_next    = ST_DONE;
                end
                else
                begin
                    we           = 1'b1;
                    waddr        = {kind_reg, n_reg[RB-1:0]};
                    wdata        = {start_reg, stop_reg};
                    held_we      = 1'b1;
                    n_next       = n_reg + CW'(1);
                    i_next       = '0;
                    swapped_next = 1'b0;
                    state_next   = ST_S_RD;
                end
            end
            ST_S_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_S_CHK;
            end
            ST_S_CHK:
            begin
                waddr = {kind_reg, i_reg[RB-1:0] - RB'(1)};
                if (i_reg == '0)
                begin
                    carry_next = rdata_reg;
                end
                else if (carry_gt)
                begin
                    we           = 1'b1;
                    wdata        = rdata_reg;
                    swapped_next = 1'b1;
                end
                else
                begin
                    we         = 1'b1;
                    wdata      = carry_reg;
                    carry_next = rdata_reg;
                end
                i_next     = i_inc;
                state_next = (i_inc == n_reg) ? ST_S_END : ST_S_RD;
            end
            ST_S_END:
            begin
                we    = 1'b1;
                waddr = {kind_reg, n_reg[RB-1:0] - RB'(1)};
                wdata = carry_reg;
                i_next       = '0;
                swapped_next = 1'b0;
                state_next   = swapped_reg ? ST_S_RD : ST_DONE;
            end
            ST_A_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_A_CHK;
            end
            ST_A_CHK:
            begin
                if (SW'(rd_begin) >= fit_end)
                begin
                    state_next = ST_A_END;
                end
                else
                begin
                    base_next  = rd_finish;
                    i_next     = i_inc;
                    state_next = (i_inc == n_reg) ? ST_A_END : ST_A_RD;
                end
            end
            ST_A_END:
            begin
                res_idx_next = base_x[15:0];
                if ((fit_end >> IW) != '0)
                begin
                    res_ovf_next = 1'b1;
                    state_next   = ST_DONE;
                end
                else
                begin
                    start_next = base_reg;
                    stop_next  = fit_end[IW-1:0];
                    i_next     = '0;
                    state_next = (n_reg == '0) ? ST_C_MISS : ST_C_RD;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    index_next     = res_idx_reg;
                    full_next      = res_full_reg;
                    ovf_next       = res_ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            i_reg         <= '0;
            for (int k = 0; k < (1 << KB); k++)
            begin
                held_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            if (held_we)
            begin
                held_reg[kind_reg] <= n_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        start_reg    <= start_next;
        stop_reg     <= stop_next;
        amount_reg   <= amount_next;
        base_reg     <= base_next;
        carry_reg    <= carry_next;
        swapped_reg  <= swapped_next;
        res_idx_reg  <= res_idx_next;
        res_full_reg <= res_full_next;
        res_ovf_reg  <= res_ovf_next;
        index_reg    <= index_next;
        full_reg     <= full_next;
        ovf_reg      <= ovf_next;
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign index          = index_reg;
    assign table_full     = full_reg;
    assign index_overflow = ovf_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(n_reg) <= MAX_RANGES)
        else $error("range count above table size");

    a_sort_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_S_RD || state_reg == ST_S_CHK) |-> (i_reg < n_reg))
        else $error("sort pass index past held ranges");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("accepted beat did not make the block busy");

    a_no_full_and_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(table_full && index_overflow))
        else $error("both error flags set on one result");
`endif

endmodule
`default_nettype wire
